### rtl/grid_bilinear_sampler_top_defines.svh
// Assertion macros for the grid bilinear sampler.
`ifndef GRID_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define GRID_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbs assertion failed");
`define GBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbs assertion failed");
`else
`define GBS_ASSERT_NOW(lbl, ante, cons)
`define GBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/gbs_pkg.sv
// Shared types, constants and helper functions of the grid bilinear sampler.
`timescale 1ns / 1ps
package gbs_pkg;
    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int IDX_W_R = (MAX_ROWS > MAX_COLS) ? $clog2(MAX_ROWS) : $clog2(MAX_COLS);
    localparam int IDX_W = (IDX_W_R < 2) ? 2 : IDX_W_R;
    localparam int QW = IDX_W + 16;
    localparam int DIV_LAT = QW + 4;
    localparam int BLEND_LAT = 5;
    localparam int PIPE_LAT = DIV_LAT + 2 + BLEND_LAT;
    localparam int BANK_AW = 2 * IDX_W - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_SPACING_X = 3'd2;
    localparam logic [2:0] REG_SPACING_Y = 3'd3;
    localparam logic [2:0] REG_ROW_COUNT = 3'd4;
    localparam logic [2:0] REG_COL_COUNT = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_HOLE    = 2'd2
    } status_t;

    typedef struct packed {
        logic               hole;
        logic signed [31:0] height;
    } cell_t;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        cell_t      entry;
    } wr_t;

    typedef struct packed {
        logic [IDX_W-1:0] r0;
        logic [IDX_W-1:0] r1;
        logic [IDX_W-1:0] k0;
        logic [IDX_W-1:0] k1;
    } rd_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [16:0]      t;
    } axis_t;

    function automatic logic [IDX_W:0] eff_cnt(logic [8:0] c, int cap);
        logic [IDX_W:0] r;
        if (int'(c) > cap)
            r = (IDX_W+1)'(cap);
        else
            r = (IDX_W+1)'(c);
        return r;
    endfunction

    function automatic axis_t axis_corner(logic [QW-1:0] f, logic [IDX_W:0] n);
        logic signed [IDX_W+2:0] lim;
        logic signed [IDX_W+2:0] i0;
        logic signed [IDX_W+2:0] ic;
        logic signed [IDX_W+2:0] ic1;
        axis_t c;
        lim = $signed({2'b00, n}) - $signed((IDX_W+3)'(2));
        i0 = $signed({3'b000, f[QW-1:16]});
        ic = (i0 < lim) ? i0 : lim;
        ic1 = ic + $signed((IDX_W+3)'(1));
        c.lo = ic[IDX_W+2] ? '0 : ic[IDX_W-1:0];
        c.hi = ic1[IDX_W-1:0];
        c.t = {i0 != ic, f[15:0]};
        return c;
    endfunction
endpackage

### rtl/gbs_ifs.sv
// Valid/ready channel interfaces for command and result words.
`timescale 1ns / 1ps
interface gbs_cmd_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [47:0] query_x;
    logic signed [47:0] query_y;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic signed [31:0] cell_height;
    logic               cell_hole;
    modport source (output valid, op, query_x, query_y, cell_row, cell_col,
                    cell_height, cell_hole, input ready);
    modport sink (input valid, op, query_x, query_y, cell_row, cell_col,
                  cell_height, cell_hole, output ready);
endinterface

interface gbs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] height;
    logic [1:0]         status;
    modport source (output valid, height, status, input ready);
    modport sink (input valid, height, status, output ready);
endinterface

### rtl/gbs_div.sv
// Pipelined restoring divider that turns one coordinate into a Q.16 grid index.
`timescale 1ns / 1ps
module gbs_div (
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [47:0]      pos,
    input  logic signed [47:0]      org,
    input  logic signed [47:0]      sp,
    input  logic [gbs_pkg::IDX_W:0] cnt,
    output logic                    outside,
    output logic [gbs_pkg::QW-1:0]  frac
);
    import gbs_pkg::*;

    logic signed [48:0] diff_reg;
    logic [47:0]        dabs_reg;
    logic               spz1_reg;
    logic               spneg_reg;
    logic [48:0]        m_reg;
    logic [47:0]        d2_reg;
    logic               spz2_reg;
    logic               neg_reg;
    logic [47:0]        rem_reg [QW+1];
    logic [47:0]        d_reg [QW+1];
    logic [QW-1:0]      nb_reg [QW+1];
    logic [QW-1:0]      q_reg [QW+1];
    logic               pre_reg [QW+1];
    logic               outside_reg;
    logic [QW-1:0]      frac_reg;
    logic [48+IDX_W:0]  lim_next;

    assign lim_next = {1'b0, d2_reg, {IDX_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= {pos[47], pos} - {org[47], org};
            dabs_reg <= sp[47] ? 48'(-sp) : 48'(sp);
            spz1_reg <= (sp == '0);
            spneg_reg <= sp[47];
            m_reg <= diff_reg[48] ? 49'(-diff_reg) : 49'(diff_reg);
            d2_reg <= dabs_reg;
            spz2_reg <= spz1_reg;
            neg_reg <= diff_reg[48] ^ spneg_reg;
            pre_reg[0] <= !spz2_reg && ((m_reg != '0 && neg_reg) ||
                          ({{IDX_W{1'b0}}, m_reg} >= lim_next));
            rem_reg[0] <= spz2_reg ? '0 : 48'(m_reg >> IDX_W);
            d_reg[0] <= spz2_reg ? '1 : d2_reg;
            nb_reg[0] <= spz2_reg ? '0 : {m_reg[IDX_W-1:0], 16'h0000};
            q_reg[0] <= '0;
            outside_reg <= pre_reg[QW] || ({1'b0, q_reg[QW][QW-1:16]} >= cnt);
            frac_reg <= q_reg[QW];
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [48:0] trial;
        logic        ge;
        assign trial = {rem_reg[k-1], nb_reg[k-1][QW-1]};
        assign ge = (trial >= {1'b0, d_reg[k-1]});
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= ge ? 48'(trial - {1'b0, d_reg[k-1]}) : trial[47:0];
                d_reg[k] <= d_reg[k-1];
                nb_reg[k] <= {nb_reg[k-1][QW-2:0], 1'b0};
                q_reg[k] <= {q_reg[k-1][QW-2:0], ge};
                pre_reg[k] <= pre_reg[k-1];
            end
        end
    end

    assign outside = outside_reg;
    assign frac = frac_reg;
endmodule

### rtl/gbs_grid.sv
// Four-bank grid memory, banked by row and column parity for four corner reads.
`timescale 1ns / 1ps
module gbs_grid (
    input  logic                   clk,
    input  logic                   adv,
    input  logic                   wr_en,
    input  gbs_pkg::wr_t           wr,
    input  gbs_pkg::rd_req_t       rd,
    output gbs_pkg::cell_t [3:0]   corner
);
    import gbs_pkg::*;

    logic [IDX_W-1:0] wrow;
    logic [IDX_W-1:0] wcol;
    logic             wr_ok;
    logic [1:0]       sel_reg [4];
    cell_t            rdata_reg [4];

    assign wrow = IDX_W'(wr.row);
    assign wcol = IDX_W'(wr.col);
    assign wr_ok = wr_en && (int'(wr.row) < MAX_ROWS) && (int'(wr.col) < MAX_COLS);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);
        cell_t            mem [BANK_DEPTH];
        logic [IDX_W-1:0] rrow;
        logic [IDX_W-1:0] rcol;
        logic             we;
        assign rrow = (rd.r0[0] == BSEL[1]) ? rd.r0 : rd.r1;
        assign rcol = (rd.k0[0] == BSEL[0]) ? rd.k0 : rd.k1;
        assign we = wr_ok && (wrow[0] == BSEL[1]) && (wcol[0] == BSEL[0]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (we)
                    mem[{wrow[IDX_W-1:1], wcol[IDX_W-1:1]}] <= wr.entry;
                rdata_reg[b] <= mem[{rrow[IDX_W-1:1], rcol[IDX_W-1:1]}];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_reg[0] <= {rd.r0[0], rd.k0[0]};
            sel_reg[1] <= {rd.r0[0], rd.k1[0]};
            sel_reg[2] <= {rd.r1[0], rd.k0[0]};
            sel_reg[3] <= {rd.r1[0], rd.k1[0]};
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            corner[c] = rdata_reg[sel_reg[c]];
    end
endmodule

### rtl/gbs_blend.sv
// Five-stage bilinear blend with exact products, floor and saturation.
`timescale 1ns / 1ps
module gbs_blend (
    input  logic                 clk,
    input  logic                 adv,
    input  gbs_pkg::cell_t [3:0] corner,
    input  logic                 outside,
    input  logic [16:0]          tj,
    input  logic [16:0]          ti,
    output logic signed [31:0]   height,
    output gbs_pkg::status_t     status
);
    import gbs_pkg::*;

    logic signed [17:0] wj;
    logic signed [17:0] tjs;
    logic signed [49:0] p_reg [4];
    logic signed [17:0] wi1_reg, ti1_reg, wi2_reg, ti2_reg;
    status_t            st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    logic signed [50:0] top_reg, bot_reg;
    logic signed [52:0] ahw_reg, bht_reg;
    logic signed [34:0] alw_reg, blt_reg;
    logic signed [53:0] hi_reg;
    logic signed [35:0] lo_reg;
    logic signed [31:0] h_reg;
    logic signed [53:0] s;
    logic signed [37:0] h;
    logic signed [31:0] hsat;
    status_t            st_next;

    assign wj = 18'sd65536 - $signed({1'b0, tj});
    assign tjs = $signed({1'b0, tj});

    always_comb
    begin
        if (outside)
            st_next = ST_OUTSIDE;
        else if (corner[0].hole || corner[1].hole || corner[2].hole || corner[3].hole)
            st_next = ST_HOLE;
        else
            st_next = ST_OK;
    end

    assign s = hi_reg + {{34{lo_reg[35]}}, lo_reg[35:16]};
    assign h = s[53:16];

    always_comb
    begin
        if (h[37:31] == 7'h00 || h[37:31] == 7'h7F)
            hsat = h[31:0];
        else if (h[37])
            hsat = 32'sh8000_0000;
        else
            hsat = 32'sh7FFF_FFFF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= corner[0].height * wj;
            p_reg[1] <= corner[1].height * tjs;
            p_reg[2] <= corner[2].height * wj;
            p_reg[3] <= corner[3].height * tjs;
            wi1_reg <= 18'sd65536 - $signed({1'b0, ti});
            ti1_reg <= $signed({1'b0, ti});
            st1_reg <= st_next;
            top_reg <= 51'(p_reg[0]) + 51'(p_reg[1]);
            bot_reg <= 51'(p_reg[2]) + 51'(p_reg[3]);
            wi2_reg <= wi1_reg;
            ti2_reg <= ti1_reg;
            st2_reg <= st1_reg;
            ahw_reg <= $signed(top_reg[50:16]) * wi2_reg;
            alw_reg <= $signed({1'b0, top_reg[15:0]}) * wi2_reg;
            bht_reg <= $signed(bot_reg[50:16]) * ti2_reg;
            blt_reg <= $signed({1'b0, bot_reg[15:0]}) * ti2_reg;
            st3_reg <= st2_reg;
            hi_reg <= 54'(ahw_reg) + 54'(bht_reg);
            lo_reg <= 36'(alw_reg) + 36'(blt_reg);
            st4_reg <= st3_reg;
            h_reg <= (st4_reg == ST_OK) ? hsat : '0;
            st5_reg <= st4_reg;
        end
    end

    assign height = h_reg;
    assign status = st5_reg;
endmodule

### rtl/grid_bilinear_sampler_top.sv
// Top level of the grid bilinear sampler: configuration, item pipeline and result register.
// Takes one word per cycle, write or query, unless the result side stalls, and returns
// one result word per query after the dividers, the grid read and the blend stages.
// The latency is set by the two restoring dividers, one quotient bit per stage, that
// map x and y to grid indices in parallel. The grid sits in four banks split by row
// and column parity, so the four corner cells of a query are read in the same cycle; a
// write lands in the bank at the same pipeline point, keeping reads and writes in order.
// Cells that were never written read back as unknown values.
`timescale 1ns / 1ps
`include "grid_bilinear_sampler_top_defines.svh"
module grid_bilinear_sampler_top (
    input  logic        clk,
    input  logic        rst_n,
    gbs_cmd_if.sink     cmd,
    gbs_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import gbs_pkg::*;

    logic signed [47:0] org_x_reg, org_y_reg, sp_x_reg, sp_y_reg;
    logic [8:0]         row_cnt_reg, col_cnt_reg;
    logic [IDX_W:0]     nr, nc;
    logic               adv;
    logic               acc;
    logic [PIPE_LAT-1:0] qv_reg;
    logic [DIV_LAT:0]   wv_reg;
    wr_t                wr_reg [DIV_LAT+1];
    logic               out_x, out_y;
    logic [QW-1:0]      fj, fi;
    axis_t              ax_j, ax_i;
    rd_req_t            rd_reg;
    logic [16:0]        tj_reg, ti_reg, tj_g_reg, ti_g_reg;
    logic               outx_reg, outg_reg;
    cell_t [3:0]        corner;
    logic signed [31:0] bl_height;
    status_t            bl_status;
    logic               out_v_reg;
    logic signed [31:0] height_reg;
    status_t            status_reg;

    assign adv = !out_v_reg || rsp.ready;
    assign cmd.ready = adv;
    assign acc = cmd.valid && adv;
    assign nr = eff_cnt(row_cnt_reg, MAX_ROWS);
    assign nc = eff_cnt(col_cnt_reg, MAX_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            sp_x_reg <= 48'sd65536;
            sp_y_reg <= 48'sd65536;
            row_cnt_reg <= 9'd256;
            col_cnt_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:  org_x_reg <= cfg_data;
                REG_ORIGIN_Y:  org_y_reg <= cfg_data;
                REG_SPACING_X: sp_x_reg <= cfg_data;
                REG_SPACING_Y: sp_y_reg <= cfg_data;
                REG_ROW_COUNT: row_cnt_reg <= cfg_data[8:0];
                REG_COL_COUNT: col_cnt_reg <= cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    gbs_div u_div_x (
        .clk(clk), .adv(adv), .pos(cmd.query_x), .org(org_x_reg), .sp(sp_x_reg),
        .cnt(nc), .outside(out_x), .frac(fj)
    );

    gbs_div u_div_y (
        .clk(clk), .adv(adv), .pos(cmd.query_y), .org(org_y_reg), .sp(sp_y_reg),
        .cnt(nr), .outside(out_y), .frac(fi)
    );

    assign ax_j = axis_corner(fj, nc);
    assign ax_i = axis_corner(fi, nr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= '0;
            wv_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            qv_reg <= {qv_reg[PIPE_LAT-2:0], acc && (cmd.op == OP_QUERY)};
            wv_reg <= {wv_reg[DIV_LAT-1:0], acc && (cmd.op == OP_WRITE)};
            out_v_reg <= qv_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wr_reg[0] <= '{row: cmd.cell_row, col: cmd.cell_col,
                           entry: '{hole: cmd.cell_hole, height: cmd.cell_height}};
            for (int k = 1; k <= DIV_LAT; k++)
                wr_reg[k] <= wr_reg[k-1];
            rd_reg <= '{r0: ax_i.lo, r1: ax_i.hi, k0: ax_j.lo, k1: ax_j.hi};
            tj_reg <= ax_j.t;
            ti_reg <= ax_i.t;
            outx_reg <= out_x || out_y;
            tj_g_reg <= tj_reg;
            ti_g_reg <= ti_reg;
            outg_reg <= outx_reg;
            height_reg <= bl_height;
            status_reg <= bl_status;
        end
    end

    gbs_grid u_grid (
        .clk(clk), .adv(adv), .wr_en(wv_reg[DIV_LAT]), .wr(wr_reg[DIV_LAT]),
        .rd(rd_reg), .corner(corner)
    );

    gbs_blend u_blend (
        .clk(clk), .adv(adv), .corner(corner), .outside(outg_reg),
        .tj(tj_g_reg), .ti(ti_g_reg), .height(bl_height), .status(bl_status)
    );

    assign rsp.valid = out_v_reg;
    assign rsp.height = height_reg;
    assign rsp.status = status_reg;

    `GBS_ASSERT_NOW(a_fail_zero, out_v_reg && status_reg != ST_OK, height_reg == '0)
    `GBS_ASSERT_NEXT(a_stall_freeze, !adv, $stable(qv_reg) && $stable(wv_reg))
    `GBS_ASSERT_NOW(a_block_only_full, !cmd.ready, out_v_reg && !rsp.ready)
endmodule
